// ----- design/modexp_pkg.sv -----
`default_nettype none

package modexp_pkg;

  localparam int unsigned ValW = 31;
  localparam int unsigned ExpW = 63;
  localparam int unsigned PcW  = 3;

  // jump conditions
  localparam logic [1:0] J_NEXT   = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_ZERO   = 2'd2;
  localparam logic [1:0] J_EVEN   = 2'd3;

  // program steps
  localparam logic [PcW-1:0] S_WAIT   = 3'd0;
  localparam logic [PcW-1:0] S_REDUCE = 3'd1;
  localparam logic [PcW-1:0] S_TESTZ  = 3'd2;
  localparam logic [PcW-1:0] S_TESTB  = 3'd3;
  localparam logic [PcW-1:0] S_MULACC = 3'd4;
  localparam logic [PcW-1:0] S_SQUARE = 3'd5;
  localparam logic [PcW-1:0] S_SHIFT  = 3'd6;
  localparam logic [PcW-1:0] S_FINISH = 3'd7;

  typedef struct packed {
    logic           wait_start;
    logic           mul;
    logic           a_acc;    // multiplier a: acc, else sq
    logic           b_sq;     // multiplier b: sq, else constant one
    logic           dst_acc;  // product goes to acc, else sq
    logic           shift;
    logic           fin;
    logic [1:0]     jcond;
    logic [PcW-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic mul_done;
    logic pwr_zero;
    logic pwr_odd;
  } seq_status_t;

  typedef struct packed {
    ctl_word_t word;
    logic      go;
    logic      mul_start;
  } seq_ctl_t;

  function automatic ctl_word_t ucode_word(input logic [PcW-1:0] pc);
    ctl_word_t w;
    w = '0;
    unique case (pc)
      S_WAIT: begin
        w.wait_start = 1'b1;
      end
      S_REDUCE: begin
        // base * 1 mod m
        w.mul = 1'b1;
      end
      S_TESTZ: begin
        w.jcond  = J_ZERO;
        w.target = S_FINISH;
      end
      S_TESTB: begin
        w.jcond  = J_EVEN;
        w.target = S_SQUARE;
      end
      S_MULACC: begin
        w.mul     = 1'b1;
        w.a_acc   = 1'b1;
        w.b_sq    = 1'b1;
        w.dst_acc = 1'b1;
      end
      S_SQUARE: begin
        w.mul  = 1'b1;
        w.b_sq = 1'b1;
      end
      S_SHIFT: begin
        w.shift  = 1'b1;
        w.jcond  = J_ALWAYS;
        w.target = S_TESTZ;
      end
      S_FINISH: begin
        w.fin    = 1'b1;
        w.jcond  = J_ALWAYS;
        w.target = S_WAIT;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/modular_exponentiation.sv -----
`default_nettype none

// Modular exponentiation, base ** exponent mod modulus, by right-to-left
// square-and-multiply. Pulse start while busy is low; the transaction is
// taken on that edge and busy stays high until the result is out. The
// result shows on power_result with done high for exactly one cycle and
// cannot be held off, so it must be captured then. With req_type high the
// exponent is ignored and modulus - 2 is used (inverse for a prime modulus).
// A modular multiply passes through a 31-step shift-add reduction unit
// plus issue and write-back; each exponent bit up to the top set bit
// costs one or two multiplies plus three sequencer steps. A modulus
// below 2 gives 0. modulus sits at byte address 0 of the configuration
// port, reset 1000000007, and is only to be written while busy is low.

module modular_exponentiation (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [1:0]                   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire                          start,
  output logic                         busy,
  input  wire                          req_type,
  input  wire  [modexp_pkg::ValW-1:0]  base_value,
  input  wire  [modexp_pkg::ExpW-1:0]  exponent_value,
  output logic                         done,
  output logic [modexp_pkg::ValW-1:0]  power_result
);
  import modexp_pkg::*;

  localparam logic [ValW-1:0] ModulusReset = 31'd1000000007;

  logic [ValW-1:0] modulus;
  logic [ValW-1:0] acc;
  logic [ValW-1:0] sq;
  logic [ExpW-1:0] pwr;
  logic [ValW-1:0] mul_a;
  logic [ValW-1:0] mul_b;
  logic [ValW-1:0] mul_res;
  logic            mul_done;
  logic            mod_small;
  seq_status_t     status;
  seq_ctl_t        ctl;

  // configuration register
  assign pready = 1'b1;
  assign prdata = {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModulusReset;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      modulus <= pwdata[ValW-1:0];
    end
  end

  assign status.mul_done = mul_done;
  assign status.pwr_zero = (pwr == '0);
  assign status.pwr_odd  = pwr[0];

  modexp_ucode u_ucode (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl)
  );

  assign busy = !ctl.word.wait_start;

  assign mul_a = ctl.word.a_acc ? acc : sq;
  assign mul_b = ctl.word.b_sq ? sq : ValW'(1);

  modexp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus),
    .done   (mul_done),
    .result (mul_res)
  );

  assign mod_small = (modulus < ValW'(2));

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (ctl.word.wait_start) begin
        sq  <= base_value;
        acc <= mod_small ? '0 : ValW'(1);
        if (mod_small) begin
          pwr <= '0;
        end else if (req_type) begin
          pwr <= ExpW'(modulus - ValW'(2));
        end else begin
          pwr <= exponent_value;
        end
      end
      if (ctl.word.mul) begin
        if (ctl.word.dst_acc) begin
          acc <= mul_res;
        end else begin
          sq <= mul_res;
        end
      end
      if (ctl.word.shift) begin
        pwr <= {1'b0, pwr[ExpW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.go && ctl.word.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.word.fin) begin
      power_result <= acc;
    end
  end

endmodule

`default_nettype wire

// ----- design/modexp_mulmod.sv -----
`default_nettype none

module modexp_mulmod (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire  [modexp_pkg::ValW-1:0]    a,
  input  wire  [modexp_pkg::ValW-1:0]    b,
  input  wire  [modexp_pkg::ValW-1:0]    m,
  output logic                           done,
  output logic [modexp_pkg::ValW-1:0]    result
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(ValW);

  logic                 running;
  logic [CntW-1:0]      cnt;
  logic [ValW-1:0]      a_sh;
  logic [ValW-1:0]      b_reg;
  logic [ValW-1:0]      r;
  logic [ValW-1:0]      r_next;
  logic [ValW:0]        dbl;
  logic [ValW:0]        dbl_red;
  logic [ValW:0]        sum;

  // msb-first interleaved multiply, residue kept below m each step
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (a_sh[ValW-1] ? {1'b0, b_reg} : '0);
    r_next  = (sum >= {1'b0, m}) ? ValW'(sum - {1'b0, m}) : sum[ValW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(ValW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      b_reg <= b;
      r     <= '0;
    end else if (running) begin
      a_sh <= {a_sh[ValW-2:0], 1'b0};
      r    <= r_next;
    end
  end

  assign result = r;

endmodule

`default_nettype wire

// ----- design/modexp_ucode.sv -----
`default_nettype none

module modexp_ucode (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire modexp_pkg::seq_status_t status,
  output modexp_pkg::seq_ctl_t       ctl
);
  import modexp_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           mul_issued;
  ctl_word_t      w;
  logic           go;
  logic           take;

  always_comb begin
    w = ucode_word(pc);
    if (w.wait_start) begin
      go = start;
    end else if (w.mul) begin
      go = status.mul_done;
    end else begin
      go = 1'b1;
    end
    unique case (w.jcond)
      J_NEXT:   take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_ZERO:   take = status.pwr_zero;
      J_EVEN:   take = !status.pwr_odd;
      default:  take = 1'b0;
    endcase
    if (!go) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = w.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= S_WAIT;
      mul_issued <= 1'b0;
    end else begin
      pc <= pc_next;
      if (w.mul && !mul_issued) begin
        mul_issued <= 1'b1;
      end else if (go) begin
        mul_issued <= 1'b0;
      end
    end
  end

  assign ctl.word      = w;
  assign ctl.go        = go;
  assign ctl.mul_start = w.mul && !mul_issued;

endmodule

`default_nettype wire

// ----- dv/modular_exponentiation_test.sv -----
`default_nettype none

module modular_exponentiation_test;
  import modexp_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned RandomPerPhase = 25;
  localparam logic [1:0] ModulusAddr = 2'd0;
  localparam logic [ValW-1:0] ModulusAtReset = 31'd1000000007;
  localparam bit KindPower = 1'b0;
  localparam bit KindInverse = 1'b1;
  localparam logic [ExpW-1:0] ExpAllOnes = {ExpW{1'b1}};

  typedef struct {
    logic [31:0]     modulus;
    bit              kind;
    logic [ValW-1:0] base;
    logic [ExpW-1:0] expo;
    bit              known;
    logic [ValW-1:0] want;
  } vector_t;

  typedef struct packed {
    logic            known;
    logic [ValW-1:0] val;
  } typed_want_t;

  // known answers only where they are obvious, the rest from the predictor
  vector_t dir_table [26] = '{
    '{32'd1000000007, KindPower, 31'd2, 63'd10, 1'b1, 31'd1024},
    '{32'd1000000007, KindPower, 31'd0, 63'd0, 1'b1, 31'd1},
    '{32'd1000000007, KindPower, 31'd5, 63'd0, 1'b1, 31'd1},
    '{32'd1000000007, KindPower, 31'd5, 63'd1, 1'b1, 31'd5},
    '{32'd1000000007, KindPower, 31'h7FFFFFFF, 63'd1, 1'b1, 31'd147483633},
    '{32'd1000000007, KindPower, 31'd1000000007, 63'd5, 1'b1, 31'd0},
    '{32'd1000000007, KindPower, 31'd1000000006, ExpAllOnes, 1'b1, 31'd1000000006},
    '{32'd1000000007, KindPower, 31'd1000000006, 63'd2, 1'b1, 31'd1},
    '{32'd1000000007, KindInverse, 31'd2, ExpAllOnes, 1'b1, 31'd500000004},
    '{32'd1000000007, KindInverse, 31'd0, 63'd0, 1'b1, 31'd0},
    '{32'd1000000007, KindInverse, 31'd1, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1, 31'd1},
    '{32'd1000000007, KindPower, 31'd3, 63'h4000_0000_0000_0000, 1'b0, 31'd0},
    '{32'd1000000007, KindPower, 31'h7FFFFFFF, 63'h7FFF_FFFF_FFFF_FFFE, 1'b0, 31'd0},
    // modulus 2: inverse power is zero, so even a zero base gives 1
    '{32'd2, KindInverse, 31'd0, 63'd99, 1'b1, 31'd1},
    '{32'd2, KindInverse, 31'd3, 63'd0, 1'b1, 31'd1},
    '{32'd2, KindPower, 31'd7, 63'd5, 1'b1, 31'd1},
    '{32'd2, KindPower, 31'd4, 63'd3, 1'b1, 31'd0},
    '{32'h7FFFFFFF, KindInverse, 31'd2, 63'd0, 1'b1, 31'd1073741824},
    '{32'h7FFFFFFF, KindPower, 31'h7FFFFFFE, ExpAllOnes, 1'b1, 31'h7FFFFFFE},
    '{32'h7FFFFFFF, KindPower, 31'h7FFFFFFF, 63'd3, 1'b1, 31'd0},
    '{32'h7FFFFFFF, KindPower, 31'd12345, 63'h1234_5678_9ABC_DEF0, 1'b0, 31'd0},
    // modulus below 2 has no residue
    '{32'd1, KindPower, 31'd5, 63'd0, 1'b1, 31'd0},
    '{32'd1, KindInverse, 31'd3, 63'd0, 1'b1, 31'd0},
    // bit 31 lies outside the register, leaving modulus 0
    '{32'h8000_0000, KindPower, 31'd5, 63'd3, 1'b1, 31'd0},
    '{32'h8000_0000, KindInverse, 31'd0, 63'd0, 1'b1, 31'd0},
    // composite modulus, inverse formula still applied
    '{32'd1000, KindInverse, 31'd7, 63'd0, 1'b0, 31'd0}
  };

  logic            clk;
  logic            rst = 1'b1;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [1:0]      paddr = ModulusAddr;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            start = 1'b0;
  logic            busy;
  logic            req_type = 1'b0;
  logic [ValW-1:0] base_value = '0;
  logic [ExpW-1:0] exponent_value = '0;
  logic            done;
  logic [ValW-1:0] power_result;

  logic [ValW-1:0] cur_modulus = ModulusAtReset;
  logic [31:0]     written_word = 32'd1000000007;
  logic [ValW-1:0] power_q [$];
  typed_want_t     want_q [$];
  typed_want_t     next_want;
  logic [ValW-1:0] oldest;

  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings = 0;
  int unsigned cycles = 0;

  int unsigned     ph;
  int unsigned     n;
  int unsigned     ew;
  bit              rkind;
  logic [ValW-1:0] rbase;
  logic [ExpW-1:0] rexp;
  logic [31:0]     mword;

  modular_exponentiation u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .done           (done),
    .power_result   (power_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ValW-1:0] expected_power(bit kind, logic [ValW-1:0] b,
                                                     logic [ExpW-1:0] e,
                                                     logic [ValW-1:0] m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned pw;
    longint unsigned mm;
    mm = m;
    if (mm < 2) return '0;
    pw = kind ? mm - 2 : e;
    acc = 1;
    sq = b % mm;
    while (pw != 0) begin
      if ((pw & 1) != 0) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      pw = pw >> 1;
    end
    return acc[ValW-1:0];
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) $display("error: %s", msg);
  endtask

  // waits for idle, writes the modulus, then reads it back
  task automatic set_modulus(logic [31:0] word);
    do @(posedge clk); while (power_q.size() != 0 || busy);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ModulusAddr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_modulus = word[ValW-1:0];
    written_word = word;
    settings++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ValW-1:0] !== cur_modulus)
      report_error($sformatf("modulus readback expected %0d got %0d",
                             cur_modulus, prdata[ValW-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(bit kind, logic [ValW-1:0] b, logic [ExpW-1:0] e,
                           bit known, logic [ValW-1:0] want);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    want_q.push_back({known, want});
    start <= 1'b1;
    req_type <= kind;
    base_value <= b;
    exponent_value <= e;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    items_sent++;
  endtask

  // prediction at acceptance, checking at done
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        next_want = '0;
        if (want_q.size() != 0) next_want = want_q.pop_front();
        power_q.push_back(next_want.known ? next_want.val :
                          expected_power(req_type, base_value, exponent_value, cur_modulus));
      end
      if (done) begin
        results_seen++;
        if (power_q.size() == 0) begin
          report_error($sformatf("power_result %0d with no transaction outstanding",
                                 power_result));
        end else begin
          oldest = power_q.pop_front();
          if (power_result !== oldest)
            report_error($sformatf("power_result expected %0d got %0d (modulus %0d)",
                                   oldest, power_result, cur_modulus));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d transactions outstanding",
               cycles, power_q.size());
      $display("modular_exponentiation test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 32;
    foreach (dir_table[i]) begin
      if (dir_table[i].modulus != written_word) set_modulus(dir_table[i].modulus);
      send_item(dir_table[i].kind, dir_table[i].base, dir_table[i].expo,
                dir_table[i].known, dir_table[i].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 86 : 0;
      for (n = 0; n < RandomPerPhase; n++) begin
        if (n % 12 == 0) begin
          case ($urandom_range(5))
            0: mword = 32'd1000000007;
            1: mword = 32'h7FFFFFFF;
            2: mword = 32'd998244353;
            3: mword = 32'd2;
            4: mword = 32'd13;
            default: mword = $urandom_range(32'h7FFFFFFF, 2);
          endcase
          mword[31] = 1'($urandom_range(1));
          set_modulus(mword);
        end
        rkind = ($urandom_range(3) == 0) ? KindInverse : KindPower;
        case ($urandom_range(3))
          0: rbase = ValW'($urandom);
          1: rbase = ValW'($urandom_range(10));
          2: rbase = cur_modulus - ValW'($urandom_range(3));
          default: rbase = 31'h7FFFFFFF - ValW'($urandom_range(3));
        endcase
        // exponent width spread evenly so short and full-length runs both occur
        ew = $urandom_range(ExpW);
        rexp = ExpW'({$urandom, $urandom});
        if (ew < ExpW) rexp = rexp & ((63'd1 << ew) - 63'd1);
        send_item(rkind, rbase, rexp, 1'b0, '0);
      end
    end

    do @(posedge clk); while (power_q.size() != 0 || busy);
    repeat (40) @(posedge clk);
    if (power_q.size() != 0)
      report_error($sformatf("%0d transactions never returned a result", power_q.size()));

    $display("%0d transactions (%0d directed), %0d results, %0d modulus settings",
             items_sent, $size(dir_table), results_seen, settings);
    $display("power and inverse mode, sender idle 32/86/0 percent, %0d errors", errors);
    if (errors == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
